### design/reachability_label_query_core_assert.svh
// ----------------------------------------------------------------------------
// Reachability label query core assertion macros
// Shorthand for clocked concurrent checks that are disabled during reset.
// ----------------------------------------------------------------------------
`ifndef REACHABILITY_LABEL_QUERY_CORE_ASSERT_SVH
`define REACHABILITY_LABEL_QUERY_CORE_ASSERT_SVH

// Checks a property on every rising edge of clk outside reset.
`define RLQ_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checks that a condition never holds on a rising edge of clk outside reset.
`define RLQ_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

### design/rlq_pkg.sv
// ----------------------------------------------------------------------------
// Reachability label query package
// Field widths, action and decision codes, the vertex record layout and the
// command and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package rlq_pkg;

	localparam int VTX_W  = 10;
	localparam int ADDR_W = 14;
	localparam int LEN_W  = 9;
	localparam int VAL_W  = 16;
	localparam int ACT_W  = 2;
	localparam int DEC_W  = 3;
	localparam int RED_CNT_W = 4;

	localparam logic [ACT_W-1:0] ACT_RECORD = 2'd0;
	localparam logic [ACT_W-1:0] ACT_LABEL  = 2'd1;
	localparam logic [ACT_W-1:0] ACT_QUERY  = 2'd2;
	localparam logic [ACT_W-1:0] ACT_NOP    = 2'd3;

	localparam logic [DEC_W-1:0] DEC_SAME  = 3'd0;
	localparam logic [DEC_W-1:0] DEC_COMP  = 3'd1;
	localparam logic [DEC_W-1:0] DEC_RANK  = 3'd2;
	localparam logic [DEC_W-1:0] DEC_LABEL = 3'd3;
	localparam logic [DEC_W-1:0] DEC_NONE  = 3'd4;

	typedef struct packed {
		logic [VTX_W-1:0]  comp_id;
		logic [VTX_W-1:0]  topo_rank;
		logic [ADDR_W-1:0] out_base;
		logic [LEN_W-1:0]  out_cnt;
		logic [ADDR_W-1:0] in_base;
		logic [LEN_W-1:0]  in_cnt;
	} rec_t;

	typedef struct packed {
		logic latch;
		logic rec_we;
		logic lbl_we;
		logic load_walk;
		logic reduce_step;
		logic walk_adv_a;
		logic walk_adv_b;
	} cmd_t;

	typedef struct packed {
		logic [ACT_W-1:0] act;
		logic             same_vtx;
		logic             out_range;
		logic             comp_diff;
		logic             rank_ge;
		logic             red_last;
		logic             walk_end;
		logic             walk_eq;
		logic             walk_lt;
	} status_t;

	// Number of conditional subtractions of the label depth, shifted left,
	// that bring any 14-bit label base below the depth.
	function automatic int red_steps(input longint lw);
		int s;
		s = 0;
		for (int k = 0; k < 16; k++) begin
			if ((lw << k) <= 64'd16383)
				s = k + 1;
		end
		return s;
	endfunction

endpackage

### design/rlq_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and two read ports, read data registered.
// ----------------------------------------------------------------------------
module rlq_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_a,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		rdata_a <= mem_q[raddr_a];
		rdata_b <= mem_q[raddr_b];
	end

endmodule

### design/rlq_dp.sv
// ----------------------------------------------------------------------------
// Reachability label query datapath
// Holds the accepted beat, the vertex record and label memories, the label
// base reduction and the merge-walk pointers and counters.
// ----------------------------------------------------------------------------
module rlq_dp #(
	parameter int MAX_VERTICES  = 1024,
	parameter int LABEL_WORDS   = 16384,
	parameter int MAX_LABEL_LEN = 256
) (
	input  logic                          clk,
	input  rlq_pkg::cmd_t                 cmd,
	output rlq_pkg::status_t              status,
	input  logic [rlq_pkg::ACT_W-1:0]     action,
	input  logic [rlq_pkg::VTX_W-1:0]     vertex,
	input  logic [rlq_pkg::VTX_W-1:0]     target,
	input  logic [rlq_pkg::VTX_W-1:0]     component,
	input  logic [rlq_pkg::VTX_W-1:0]     topo_rank,
	input  logic [rlq_pkg::ADDR_W-1:0]    out_start,
	input  logic [rlq_pkg::LEN_W-1:0]     out_len,
	input  logic [rlq_pkg::ADDR_W-1:0]    in_start,
	input  logic [rlq_pkg::LEN_W-1:0]     in_len,
	input  logic [rlq_pkg::ADDR_W-1:0]    label_addr,
	input  logic [rlq_pkg::VAL_W-1:0]     label_value
);

	import rlq_pkg::*;

	localparam int VAW    = $clog2(MAX_VERTICES);
	localparam int LAW    = $clog2(LABEL_WORDS);
	localparam int PW     = (LAW > ADDR_W) ? LAW : ADDR_W;
	localparam int RS     = red_steps(longint'(LABEL_WORDS));
	localparam int RSTEPS = (RS > 0) ? RS : 1;

	logic [ACT_W-1:0]  action_q;
	logic [VTX_W-1:0]  vertex_q;
	logic [VTX_W-1:0]  target_q;
	logic [VTX_W-1:0]  component_q;
	logic [VTX_W-1:0]  topo_rank_q;
	logic [ADDR_W-1:0] out_start_q;
	logic [LEN_W-1:0]  out_len_q;
	logic [ADDR_W-1:0] in_start_q;
	logic [LEN_W-1:0]  in_len_q;
	logic [ADDR_W-1:0] label_addr_q;
	logic [VAL_W-1:0]  label_value_q;

	logic [31:0]    src32;
	logic [31:0]    dst32;
	logic [31:0]    lbl32;
	logic [VAW-1:0] src_idx;
	logic [VAW-1:0] dst_idx;
	rec_t           rec_wr;
	rec_t           rec_a;
	rec_t           rec_b;
	logic           rec_we;
	logic           lbl_we;

	logic [PW-1:0]        ptr_a_q;
	logic [PW-1:0]        ptr_b_q;
	logic [PW-1:0]        ptr_a_d;
	logic [PW-1:0]        ptr_b_d;
	logic [LEN_W-1:0]     i_q;
	logic [LEN_W-1:0]     j_q;
	logic [LEN_W-1:0]     n1_q;
	logic [LEN_W-1:0]     n2_q;
	logic [RED_CNT_W-1:0] red_cnt_q;
	logic [31:0]          red_sub;
	logic [VAL_W-1:0]     lab_a;
	logic [VAL_W-1:0]     lab_b;

	function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
		if (32'(p) == 32'(LABEL_WORDS - 1))
			return '0;
		return p + PW'(1);
	endfunction

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			action_q      <= action;
			vertex_q      <= vertex;
			target_q      <= target;
			component_q   <= component;
			topo_rank_q   <= topo_rank;
			out_start_q   <= out_start;
			out_len_q     <= out_len;
			in_start_q    <= in_start;
			in_len_q      <= in_len;
			label_addr_q  <= label_addr;
			label_value_q <= label_value;
		end
	end

	assign src32   = 32'(vertex_q);
	assign dst32   = 32'(target_q);
	assign lbl32   = 32'(label_addr_q);
	assign src_idx = src32[VAW-1:0];
	assign dst_idx = dst32[VAW-1:0];

	always_comb begin
		rec_wr.comp_id   = component_q;
		rec_wr.topo_rank = topo_rank_q;
		rec_wr.out_base  = out_start_q;
		rec_wr.in_base   = in_start_q;
		rec_wr.out_cnt   = (32'(out_len_q) > 32'(MAX_LABEL_LEN)) ?
			LEN_W'(MAX_LABEL_LEN) : out_len_q;
		rec_wr.in_cnt    = (32'(in_len_q) > 32'(MAX_LABEL_LEN)) ?
			LEN_W'(MAX_LABEL_LEN) : in_len_q;
	end

	assign rec_we = cmd.rec_we && (src32 < 32'(MAX_VERTICES));
	assign lbl_we = cmd.lbl_we && (lbl32 < 32'(LABEL_WORDS));

	rlq_ram #(
		.WIDTH ($bits(rec_t)),
		.DEPTH (MAX_VERTICES)
	) u_rec_ram (
		.clk     (clk),
		.we      (rec_we),
		.waddr   (src_idx),
		.wdata   (rec_wr),
		.raddr_a (src_idx),
		.raddr_b (dst_idx),
		.rdata_a (rec_a),
		.rdata_b (rec_b)
	);

	assign red_sub = 32'(LABEL_WORDS) << red_cnt_q;

	always_comb begin
		ptr_a_d = ptr_a_q;
		ptr_b_d = ptr_b_q;
		if (cmd.load_walk) begin
			ptr_a_d = PW'(rec_a.out_base);
			ptr_b_d = PW'(rec_b.in_base);
		end else if (cmd.reduce_step) begin
			if (32'(ptr_a_q) >= red_sub)
				ptr_a_d = ptr_a_q - PW'(red_sub);
			if (32'(ptr_b_q) >= red_sub)
				ptr_b_d = ptr_b_q - PW'(red_sub);
		end else begin
			if (cmd.walk_adv_a)
				ptr_a_d = ptr_inc(ptr_a_q);
			if (cmd.walk_adv_b)
				ptr_b_d = ptr_inc(ptr_b_q);
		end
	end

	always_ff @(posedge clk) begin
		ptr_a_q <= ptr_a_d;
		ptr_b_q <= ptr_b_d;
		if (cmd.load_walk) begin
			i_q       <= '0;
			j_q       <= '0;
			n1_q      <= rec_a.out_cnt;
			n2_q      <= rec_b.in_cnt;
			red_cnt_q <= RED_CNT_W'(RSTEPS - 1);
		end else begin
			if (cmd.reduce_step)
				red_cnt_q <= red_cnt_q - RED_CNT_W'(1);
			if (cmd.walk_adv_a)
				i_q <= i_q + LEN_W'(1);
			if (cmd.walk_adv_b)
				j_q <= j_q + LEN_W'(1);
		end
	end

	rlq_ram #(
		.WIDTH (VAL_W),
		.DEPTH (LABEL_WORDS)
	) u_lbl_ram (
		.clk     (clk),
		.we      (lbl_we),
		.waddr   (lbl32[LAW-1:0]),
		.wdata   (label_value_q),
		.raddr_a (ptr_a_d[LAW-1:0]),
		.raddr_b (ptr_b_d[LAW-1:0]),
		.rdata_a (lab_a),
		.rdata_b (lab_b)
	);

	always_comb begin
		status.act       = action_q;
		status.same_vtx  = (vertex_q == target_q);
		status.out_range = (src32 >= 32'(MAX_VERTICES)) || (dst32 >= 32'(MAX_VERTICES));
		status.comp_diff = (rec_a.comp_id != rec_b.comp_id);
		status.rank_ge   = (rec_a.topo_rank >= rec_b.topo_rank);
		status.red_last  = (red_cnt_q == '0);
		status.walk_end  = (i_q >= n1_q) || (j_q >= n2_q);
		status.walk_eq   = (lab_a == lab_b);
		status.walk_lt   = (lab_a < lab_b);
	end

endmodule

### design/rlq_ctrl.sv
// ----------------------------------------------------------------------------
// Reachability label query controller
// Sequences each beat through dispatch, record check, base reduction and the
// merge walk, and registers the result strobe and answer.
// ----------------------------------------------------------------------------
`include "reachability_label_query_core_assert.svh"

module rlq_ctrl (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  rlq_pkg::status_t           status,
	output rlq_pkg::cmd_t              cmd,
	output logic                       done,
	output logic                       reachable,
	output logic [rlq_pkg::DEC_W-1:0]  decided_by
);

	import rlq_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DISPATCH,
		ST_CHECK,
		ST_REDUCE,
		ST_WALK
	} state_t;

	state_t           state_q;
	state_t           state_d;
	logic             res_valid;
	logic             res_reach;
	logic [DEC_W-1:0] res_code;
	logic             done_q;
	logic             reachable_q;
	logic [DEC_W-1:0] decided_by_q;

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		res_valid = 1'b0;
		res_reach = 1'b0;
		res_code  = DEC_NONE;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.latch = 1'b1;
					state_d   = ST_DISPATCH;
				end
			end
			ST_DISPATCH: begin
				state_d = ST_IDLE;
				unique case (status.act)
					ACT_RECORD: cmd.rec_we = 1'b1;
					ACT_LABEL:  cmd.lbl_we = 1'b1;
					ACT_QUERY: begin
						if (status.same_vtx) begin
							res_valid = 1'b1;
							res_reach = 1'b1;
							res_code  = DEC_SAME;
						end else if (status.out_range) begin
							res_valid = 1'b1;
							res_code  = DEC_NONE;
						end else begin
							state_d = ST_CHECK;
						end
					end
					default: state_d = ST_IDLE;
				endcase
			end
			ST_CHECK: begin
				if (status.comp_diff) begin
					res_valid = 1'b1;
					res_code  = DEC_COMP;
					state_d   = ST_IDLE;
				end else if (status.rank_ge) begin
					res_valid = 1'b1;
					res_code  = DEC_RANK;
					state_d   = ST_IDLE;
				end else begin
					cmd.load_walk = 1'b1;
					state_d       = ST_REDUCE;
				end
			end
			ST_REDUCE: begin
				cmd.reduce_step = 1'b1;
				if (status.red_last)
					state_d = ST_WALK;
			end
			ST_WALK: begin
				if (status.walk_end) begin
					res_valid = 1'b1;
					res_code  = DEC_NONE;
					state_d   = ST_IDLE;
				end else if (status.walk_eq) begin
					res_valid = 1'b1;
					res_reach = 1'b1;
					res_code  = DEC_LABEL;
					state_d   = ST_IDLE;
				end else if (status.walk_lt) begin
					cmd.walk_adv_a = 1'b1;
				end else begin
					cmd.walk_adv_b = 1'b1;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			done_q       <= 1'b0;
			reachable_q  <= 1'b0;
			decided_by_q <= DEC_SAME;
		end else begin
			state_q      <= state_d;
			done_q       <= res_valid;
			reachable_q  <= res_reach;
			decided_by_q <= res_code;
		end
	end

	assign busy       = (state_q != ST_IDLE);
	assign done       = done_q;
	assign reachable  = reachable_q;
	assign decided_by = decided_by_q;

	`RLQ_ASSERT(a_done_in_idle, done_q |-> (state_q == ST_IDLE), "result shown outside idle")
	`RLQ_ASSERT(a_accept_dispatch, (state_q == ST_IDLE && start) |=> (state_q == ST_DISPATCH), "accepted beat not dispatched")
	`RLQ_ASSERT(a_single_strobe, done_q |=> !done_q, "result strobe longer than one cycle")
	`RLQ_NEVER(a_reach_code, done_q && reachable_q && decided_by_q != DEC_SAME && decided_by_q != DEC_LABEL, "reachable with a negative decision code")

endmodule

### design/reachability_label_query_core.sv
// ----------------------------------------------------------------------------
// Reachability label query core
// Answers reachability queries from a two-hop label index held in on-chip
// vertex record and label memories.
// ----------------------------------------------------------------------------
// A beat is taken when start is high and busy is low; busy stays high until
// the beat is finished. Record and label word writes give no result. A query
// whose vertices match or lie out of range is answered from dispatch, one
// decided on component or rank from the record check. Otherwise the
// label bases are reduced modulo the label depth (one step a cycle, at least
// one step) and the labels are merge-walked at one comparison per cycle
// through the two read ports of the label memory. Each result appears on
// reachable and decided_by for exactly one cycle with done high and cannot
// be held off. Memories have no reset: records and label words must be
// written before a query reads them.
module reachability_label_query_core #(
	parameter int MAX_VERTICES  = 1024,
	parameter int LABEL_WORDS   = 16384,
	parameter int MAX_LABEL_LEN = 256
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  logic [rlq_pkg::ACT_W-1:0]  action,
	input  logic [rlq_pkg::VTX_W-1:0]  vertex,
	input  logic [rlq_pkg::VTX_W-1:0]  target,
	input  logic [rlq_pkg::VTX_W-1:0]  component,
	input  logic [rlq_pkg::VTX_W-1:0]  topo_rank,
	input  logic [rlq_pkg::ADDR_W-1:0] out_start,
	input  logic [rlq_pkg::LEN_W-1:0]  out_len,
	input  logic [rlq_pkg::ADDR_W-1:0] in_start,
	input  logic [rlq_pkg::LEN_W-1:0]  in_len,
	input  logic [rlq_pkg::ADDR_W-1:0] label_addr,
	input  logic [rlq_pkg::VAL_W-1:0]  label_value,
	output logic                       done,
	output logic                       reachable,
	output logic [rlq_pkg::DEC_W-1:0]  decided_by
);

	import rlq_pkg::*;

	cmd_t    cmd;
	status_t status;

	rlq_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.status     (status),
		.cmd        (cmd),
		.done       (done),
		.reachable  (reachable),
		.decided_by (decided_by)
	);

	rlq_dp #(
		.MAX_VERTICES  (MAX_VERTICES),
		.LABEL_WORDS   (LABEL_WORDS),
		.MAX_LABEL_LEN (MAX_LABEL_LEN)
	) u_dp (
		.clk         (clk),
		.cmd         (cmd),
		.status      (status),
		.action      (action),
		.vertex      (vertex),
		.target      (target),
		.component   (component),
		.topo_rank   (topo_rank),
		.out_start   (out_start),
		.out_len     (out_len),
		.in_start    (in_start),
		.in_len      (in_len),
		.label_addr  (label_addr),
		.label_value (label_value)
	);

endmodule
